[rtl/ecfr_pkg.sv]
// shared types, constants and the crc byte update for the escaped frame receiver
// depends on nothing; every rtl file imports it
package ecfr_pkg;

   // link framing bytes
   localparam logic [7:0] START_BYTE     = 8'hFE;
   localparam logic [7:0] ESC_BYTE       = 8'hFD;
   localparam logic [7:0] ESC_CODE_START = 8'h01;
   localparam logic [7:0] ESC_CODE_ESC   = 8'h02;

   // command range and minimum frame length
   localparam logic [7:0]  CMD_MIN       = 8'h01;
   localparam logic [7:0]  CMD_MAX       = 8'h08;
   localparam logic [15:0] MIN_FRAME_LEN = 16'd3;

   // crc-16, poly 0x8005, msb first
   localparam logic [15:0] CRC_POLY = 16'h8005;

   // result item kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   // frame status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_CRC_BAD   = 2'd1;
   localparam logic [1:0] ST_SHORT_LEN = 2'd2;
   localparam logic [1:0] ST_BAD_CMD   = 2'd3;

   // token queue between front and back
   localparam int TQ_DEPTH = 4;
   localparam int TQ_PTR_W = $clog2(TQ_DEPTH);
   localparam int TQ_CNT_W = $clog2(TQ_DEPTH + 1);

   // result queue at the output
   localparam int OQ_DEPTH = 2;
   localparam int OQ_PTR_W = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
   localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

   // role of one unescaped byte within the frame
   typedef enum logic [2:0] {
      TK_LEN_LO,
      TK_LEN_HI,
      TK_LEN_SHORT,
      TK_CMD,
      TK_PAYLOAD,
      TK_CRC_LO,
      TK_CRC_HI
   } tok_class_type;

   typedef struct packed {
      tok_class_type cls;
      logic [7:0]    data;
   } token_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic [7:0] cmd;
      logic [1:0] status;
   } result_type;

   // front status seen by the top level
   typedef struct packed {
      logic in_frame;
      logic escape_pending;
   } front_stat_type;

   // one byte through the crc register, eight shift steps
   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

[rtl/ecfr_front.sv]
// front end: start hunt, unescape and classification of each frame byte
// depends on ecfr_pkg
module ecfr_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              link_byte,
   output logic                    tok_valid,
   output ecfr_pkg::token_type     tok,
   output ecfr_pkg::front_stat_type stat
);
   import ecfr_pkg::*;

   logic        in_frame_ff, in_frame_in;
   logic        esc_ff, esc_in;
   logic [16:0] count_ff, count_in;
   logic [15:0] len_ff, len_in;

   logic        dvalid;
   logic [7:0]  dbyte;
   logic [15:0] len_full;

   // unescape the raw byte
   always_comb begin
      esc_in = esc_ff;
      dvalid = 1'b0;
      dbyte  = link_byte;
      if (in_frame_ff) begin
         if (esc_ff) begin
            esc_in = 1'b0;
            priority if (link_byte == ESC_CODE_START) begin
               dvalid = 1'b1;
               dbyte  = START_BYTE;
            end else if (link_byte == ESC_CODE_ESC) begin
               dvalid = 1'b1;
               dbyte  = ESC_BYTE;
            end else begin
               dvalid = 1'b0;
            end
         end else if (link_byte == ESC_BYTE) begin
            esc_in = 1'b1;
         end else begin
            dvalid = 1'b1;
         end
      end else if (link_byte == START_BYTE) begin
         esc_in = 1'b0;
      end
   end

   assign len_full = {dbyte, len_ff[7:0]};

   // classify the byte by its position in the frame
   always_comb begin
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      len_in      = len_ff;
      tok.cls     = TK_PAYLOAD;
      tok.data    = dbyte;
      if (!in_frame_ff) begin
         if (link_byte == START_BYTE) begin
            in_frame_in = 1'b1;
            count_in    = '0;
            len_in      = '0;
         end
      end else if (dvalid) begin
         count_in = count_ff + 17'd1;
         priority if (count_ff == 17'd0) begin
            tok.cls = TK_LEN_LO;
            len_in  = {8'h00, dbyte};
         end else if (count_ff == 17'd1) begin
            len_in = len_full;
            if (len_full < MIN_FRAME_LEN) begin
               tok.cls     = TK_LEN_SHORT;
               in_frame_in = 1'b0;
            end else begin
               tok.cls = TK_LEN_HI;
            end
         end else if (count_ff == 17'd2) begin
            tok.cls = TK_CMD;
         end else if (count_ff < {1'b0, len_ff}) begin
            tok.cls = TK_PAYLOAD;
         end else if (count_ff == {1'b0, len_ff}) begin
            tok.cls = TK_CRC_LO;
         end else begin
            tok.cls     = TK_CRC_HI;
            in_frame_in = 1'b0;
         end
      end
   end

   assign tok_valid = accept && in_frame_ff && dvalid;

   // frame position state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         esc_ff      <= 1'b0;
         count_ff    <= '0;
         len_ff      <= '0;
      end else if (accept) begin
         in_frame_ff <= in_frame_in;
         esc_ff      <= esc_in;
         count_ff    <= count_in;
         len_ff      <= len_in;
      end
   end

   assign stat.in_frame       = in_frame_ff;
   assign stat.escape_pending = esc_ff;

endmodule

[rtl/ecfr_token_queue.sv]
// short token queue that decouples the front end from the back end
// depends on ecfr_pkg
module ecfr_token_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr,
   input  ecfr_pkg::token_type           wdata,
   output logic                          full,
   input  logic                          rd,
   output logic                          rvalid,
   output ecfr_pkg::token_type           rdata,
   output logic [ecfr_pkg::TQ_CNT_W-1:0] level
);
   import ecfr_pkg::*;

   token_type             slot_ff [TQ_DEPTH];
   logic [TQ_PTR_W-1:0]   wptr_ff, wptr_in;
   logic [TQ_PTR_W-1:0]   rptr_ff, rptr_in;
   logic [TQ_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                  do_wr, do_rd;

   assign full   = (cnt_ff == TQ_CNT_W'(TQ_DEPTH));
   assign rvalid = (cnt_ff != '0);
   assign rdata  = slot_ff[rptr_ff];
   assign level  = cnt_ff;
   assign do_wr  = wr && !full;
   assign do_rd  = rd && rvalid;

   // pointer and fill count update
   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (do_wr) begin
         wptr_in = (wptr_ff == TQ_PTR_W'(TQ_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_rd) begin
         rptr_in = (rptr_ff == TQ_PTR_W'(TQ_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      unique case ({do_wr, do_rd})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // token storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wptr_ff] <= wdata;
      end
   end

endmodule

[rtl/ecfr_back.sv]
// back end: running crc, command capture, frame checks and the result queue
// depends on ecfr_pkg
module ecfr_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  tok_valid,
   input  ecfr_pkg::token_type   tok,
   output logic                  tok_take,
   input  logic                  pop,
   output logic                  empty,
   output ecfr_pkg::result_type  res
);
   import ecfr_pkg::*;

   logic [15:0]         crc_ff, crc_in;
   logic [7:0]          cmd_ff, cmd_in;
   logic [7:0]          crc_lo_ff, crc_lo_in;

   result_type          slot_ff [OQ_DEPTH];
   logic [OQ_PTR_W-1:0] wptr_ff, wptr_in;
   logic [OQ_PTR_W-1:0] rptr_ff, rptr_in;
   logic [OQ_CNT_W-1:0] cnt_ff, cnt_in;

   logic                pop_fire;
   logic                res_valid;
   result_type          res_new;
   logic                do_wr;

   assign empty    = (cnt_ff == '0);
   assign pop_fire = pop && !empty;
   assign tok_take = tok_valid && ((cnt_ff != OQ_CNT_W'(OQ_DEPTH)) || pop_fire);
   assign res      = slot_ff[rptr_ff];

   // per-token work
   always_comb begin
      crc_in         = crc_ff;
      cmd_in         = cmd_ff;
      crc_lo_in      = crc_lo_ff;
      res_valid      = 1'b0;
      res_new.kind   = KIND_STATUS;
      res_new.data   = 8'h00;
      res_new.cmd    = cmd_ff;
      res_new.status = ST_OK;
      unique case (tok.cls)
         TK_LEN_LO: begin
            crc_in = crc_update(16'h0000, tok.data);
            cmd_in = 8'h00;
         end
         TK_LEN_HI: begin
            crc_in = crc_update(crc_ff, tok.data);
         end
         TK_LEN_SHORT: begin
            res_valid      = 1'b1;
            res_new.status = ST_SHORT_LEN;
         end
         TK_CMD: begin
            crc_in = crc_update(crc_ff, tok.data);
            cmd_in = tok.data;
         end
         TK_PAYLOAD: begin
            crc_in       = crc_update(crc_ff, tok.data);
            res_valid    = 1'b1;
            res_new.kind = KIND_PAYLOAD;
            res_new.data = tok.data;
         end
         TK_CRC_LO: begin
            crc_lo_in = tok.data;
         end
         TK_CRC_HI: begin
            res_valid = 1'b1;
            priority if ({tok.data, crc_lo_ff} != crc_ff) begin
               res_new.status = ST_CRC_BAD;
            end else if ((cmd_ff < CMD_MIN) || (cmd_ff > CMD_MAX)) begin
               res_new.status = ST_BAD_CMD;
            end else begin
               res_new.status = ST_OK;
            end
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   // frame accumulators
   always_ff @(posedge clock) begin
      if (tok_take) begin
         crc_ff    <= crc_in;
         cmd_ff    <= cmd_in;
         crc_lo_ff <= crc_lo_in;
      end
   end

   assign do_wr = tok_take && res_valid;

   // result queue pointers and count
   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      if (do_wr) begin
         wptr_in = (wptr_ff == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rptr_in = (rptr_ff == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      unique case ({do_wr, pop_fire})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wptr_ff] <= res_new;
      end
   end

endmodule

[rtl/escaped_crc16_frame_receiver.sv]
// top level of the escaped crc-16 frame receiver
// depends on ecfr_pkg, ecfr_front, ecfr_token_queue and ecfr_back
//
//   channel   ports                                   transfer when
//   --------  --------------------------------------  ------------------
//   request   req_push, req_full, req_link_byte       push && !full
//   response  rsp_pop, rsp_empty, rsp_item_kind,      pop && !empty
//             rsp_payload_byte, rsp_command_id,
//             rsp_frame_status
//
// one link byte is taken every cycle while the token queue is not full; its result,
// if any, goes through the token queue and then the result queue to the response ports
// (front classifies into the token queue, back updates the crc into the result queue)
// the byte-wide crc update in the back end sets the cycle time
// reset is synchronous and empties both queues; the block then hunts for a start byte
// a held result stalls the back end only once the result queue is full, and the front
// end only once the token queue is full as well
module escaped_crc16_frame_receiver (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_link_byte,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic       rsp_item_kind,
   output logic [7:0] rsp_payload_byte,
   output logic [7:0] rsp_command_id,
   output logic [1:0] rsp_frame_status
);
   import ecfr_pkg::*;

   logic                tq_full;
   logic                accept;
   logic                tok_wr;
   token_type           tok_wdata;
   front_stat_type      fstat;
   logic                tq_rvalid;
   token_type           tq_rdata;
   logic                tq_rd;
   logic [TQ_CNT_W-1:0] tq_level;
   result_type          res;

   assign req_full = tq_full;
   assign accept   = req_push && !tq_full;

   // start hunt, unescape, classify
   ecfr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .link_byte (req_link_byte),
      .tok_valid (tok_wr),
      .tok       (tok_wdata),
      .stat      (fstat)
   );

   // decoupling queue
   ecfr_token_queue u_tq (
      .clock  (clock),
      .reset  (reset),
      .wr     (tok_wr),
      .wdata  (tok_wdata),
      .full   (tq_full),
      .rd     (tq_rd),
      .rvalid (tq_rvalid),
      .rdata  (tq_rdata),
      .level  (tq_level)
   );

   // crc and frame checks
   ecfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (tq_rvalid),
      .tok       (tq_rdata),
      .tok_take  (tq_rd),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .res       (res)
   );

   assign rsp_item_kind    = res.kind;
   assign rsp_payload_byte = res.data;
   assign rsp_command_id   = res.cmd;
   assign rsp_frame_status = res.status;

   // queues come out of reset empty
   assert property (@(posedge clock) reset |=> (rsp_empty && (tq_level == '0)))
      else $error("queues not empty after reset");

   // token queue never holds more than its depth
   assert property (@(posedge clock) disable iff (reset)
      tq_level <= TQ_CNT_W'(TQ_DEPTH))
      else $error("token queue level out of range");

   // a frame-closing token sends the front end back to hunting
   assert property (@(posedge clock) disable iff (reset)
      (tok_wr && ((tok_wdata.cls == TK_CRC_HI) || (tok_wdata.cls == TK_LEN_SHORT)))
      |=> !fstat.in_frame)
      else $error("front end still in frame after closing token");

   // an escape can only be pending inside a frame
   assert property (@(posedge clock) disable iff (reset)
      fstat.escape_pending |-> fstat.in_frame)
      else $error("escape pending while hunting");

endmodule

[verif/tb_escaped_crc16_frame_receiver.sv]
// testbench for escaped_crc16_frame_receiver: byte-stuffed link frames in, payload and status out
// a scoreboard class predicts each transfer from the link bytes and checks the response queue
// depends on ecfr_pkg and the escaped_crc16_frame_receiver rtl
module tb_escaped_crc16_frame_receiver;
   import ecfr_pkg::*;

   localparam int STIM_BYTES  = 1200;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_WAIT  = 8;

   // frame scoreboard: tracks the receiver state and the results it must produce
   class frame_scoreboard;
      bit          in_frame;
      bit          esc_pending;
      logic [16:0] byte_pos;
      logic [15:0] frame_len;
      logic [15:0] crc_acc;
      logic [7:0]  cmd_reg;
      logic [7:0]  crc_lo;
      result_type  expected_items[$];
      int          mismatches;

      // crc-16 over one byte, shifted in one bit at a time
      static function logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
         logic [15:0] c;
         logic        fb;
         c = crc;
         for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
         end
         return c;
      endfunction

      function void add_expected(input logic kind, input logic [7:0] data,
                                 input logic [1:0] status);
         result_type r;
         r.kind   = kind;
         r.data   = data;
         r.cmd    = cmd_reg;
         r.status = status;
         expected_items.insert(expected_items.size(), r);
      endfunction

      // one accepted link byte
      function void note_link_byte(input logic [7:0] raw);
         logic [7:0]  d;
         logic [16:0] pos;
         // hunting for a start byte
         if (!in_frame) begin
            if (raw == START_BYTE) begin
               in_frame    = 1'b1;
               esc_pending = 1'b0;
               byte_pos    = '0;
               frame_len   = '0;
               crc_acc     = '0;
               cmd_reg     = '0;
               crc_lo      = '0;
            end
            return;
         end
         // unescape
         if (esc_pending) begin
            esc_pending = 1'b0;
            if (raw == ESC_CODE_START) begin
               d = START_BYTE;
            end else if (raw == ESC_CODE_ESC) begin
               d = ESC_BYTE;
            end else begin
               return;
            end
         end else if (raw == ESC_BYTE) begin
            esc_pending = 1'b1;
            return;
         end else begin
            d = raw;
         end
         pos      = byte_pos;
         byte_pos = byte_pos + 17'd1;
         // place the byte within the frame
         if (pos == 17'd0) begin
            frame_len = {8'h00, d};
            crc_acc   = crc_byte(crc_acc, d);
         end else if (pos == 17'd1) begin
            frame_len[15:8] = d;
            crc_acc         = crc_byte(crc_acc, d);
            if (frame_len < MIN_FRAME_LEN) begin
               in_frame = 1'b0;
               add_expected(KIND_STATUS, 8'h00, ST_SHORT_LEN);
            end
         end else if (pos == 17'd2) begin
            cmd_reg = d;
            crc_acc = crc_byte(crc_acc, d);
         end else if (pos < {1'b0, frame_len}) begin
            crc_acc = crc_byte(crc_acc, d);
            add_expected(KIND_PAYLOAD, d, ST_OK);
         end else if (pos == {1'b0, frame_len}) begin
            crc_lo = d;
         end else begin
            in_frame = 1'b0;
            if ({d, crc_lo} != crc_acc) begin
               add_expected(KIND_STATUS, 8'h00, ST_CRC_BAD);
            end else if (cmd_reg < CMD_MIN || cmd_reg > CMD_MAX) begin
               add_expected(KIND_STATUS, 8'h00, ST_BAD_CMD);
            end else begin
               add_expected(KIND_STATUS, 8'h00, ST_OK);
            end
         end
      endfunction

      task report_mismatch(input string what, input int got, input int want);
         mismatches++;
         $display("mismatch %s: got %0h expected %0h", what, got, want);
      endtask

      // one result transfer against the oldest expectation
      task check_item(input result_type got);
         result_type want;
         if (expected_items.size() == 0) begin
            report_mismatch("unexpected result", int'(got), 0);
            return;
         end
         want = expected_items.pop_front();
         if (got.kind != want.kind) begin
            report_mismatch("item_kind", int'(got.kind), int'(want.kind));
         end
         if (got.data != want.data) begin
            report_mismatch("payload_byte", int'(got.data), int'(want.data));
         end
         if (got.cmd != want.cmd) begin
            report_mismatch("command_id", int'(got.cmd), int'(want.cmd));
         end
         if (got.status != want.status) begin
            report_mismatch("frame_status", int'(got.status), int'(want.status));
         end
      endtask

      function int pending();
         return expected_items.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_link_byte = 8'h00;
   logic       rsp_pop = 1'b0;
   logic       rsp_empty;
   logic       rsp_item_kind;
   logic [7:0] rsp_payload_byte;
   logic [7:0] rsp_command_id;
   logic [1:0] rsp_frame_status;

   frame_scoreboard sb = new;
   logic [7:0]      link_stream[$];
   int              n_in = 0;
   int              stall_cycles = 0;
   int              hold_left = 0;
   bit              hold_done = 1'b0;

   escaped_crc16_frame_receiver i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_link_byte    (req_link_byte),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_item_kind    (rsp_item_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_command_id   (rsp_command_id),
      .rsp_frame_status (rsp_frame_status)
   );

   always #2 clock = ~clock;

   // window with no idling on either side
   function automatic bit calm_window();
      return n_in >= 600 && n_in < 800;
   endfunction

   // append one raw byte to the link stream
   function automatic void add_link_byte(input logic [7:0] b);
      link_stream.insert(link_stream.size(), b);
   endfunction

   // one unescaped frame byte onto the link, with optional bad escape pairs in front
   task automatic put_data(input logic [7:0] b, input int stuff_pct);
      logic [7:0] junk;
      if ($urandom_range(0, 99) < stuff_pct) begin
         do junk = 8'($urandom_range(0, 255));
         while (junk == ESC_CODE_START || junk == ESC_CODE_ESC);
         add_link_byte(ESC_BYTE);
         add_link_byte(junk);
      end
      if (b == ESC_BYTE) begin
         add_link_byte(ESC_BYTE);
         add_link_byte(ESC_CODE_ESC);
      end else if (b == START_BYTE && (stuff_pct == 100 ||
                                       (stuff_pct > 0 && $urandom_range(0, 1) == 1))) begin
         add_link_byte(ESC_BYTE);
         add_link_byte(ESC_CODE_START);
      end else begin
         add_link_byte(b);
      end
   endtask

   // whole frame: start, length, command, payload, crc; a short length ends it after the length
   task automatic build_frame(input int len, input logic [7:0] cmd, input bit bad_crc,
                              input int first_pay, input int stuff_pct);
      logic [15:0] crc;
      logic [15:0] len16;
      logic [7:0]  b;
      crc   = '0;
      len16 = len[15:0];
      add_link_byte(START_BYTE);
      put_data(len16[7:0], stuff_pct);
      crc = frame_scoreboard::crc_byte(crc, len16[7:0]);
      put_data(len16[15:8], stuff_pct);
      crc = frame_scoreboard::crc_byte(crc, len16[15:8]);
      if (len16 < MIN_FRAME_LEN) return;
      put_data(cmd, stuff_pct);
      crc = frame_scoreboard::crc_byte(crc, cmd);
      for (int i = 3; i < len; i++) begin
         b = (i == 3 && first_pay >= 0) ? first_pay[7:0] : 8'($urandom_range(0, 255));
         put_data(b, stuff_pct);
         crc = frame_scoreboard::crc_byte(crc, b);
      end
      if (bad_crc) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      put_data(crc[7:0], stuff_pct);
      put_data(crc[15:8], stuff_pct);
   endtask

   // mostly well-formed frames with random content, the rest broken frames and line noise
   task automatic build_random();
      int         roll;
      int         len;
      logic [7:0] b;
      roll = $urandom_range(0, 99);
      len  = ($urandom_range(0, 99) < 2) ? $urandom_range(256, 400) : $urandom_range(3, 14);
      if (roll < 60) begin
         build_frame(len, 8'($urandom_range(1, 8)), 1'b0, -1, 10);
      end else if (roll < 72) begin
         build_frame(len, 8'($urandom_range(0, 255)), 1'b1, -1, 10);
      end else if (roll < 82) begin
         build_frame(len, ($urandom_range(0, 1) == 1) ? 8'h00 : 8'($urandom_range(9, 255)),
                     1'b0, -1, 10);
      end else if (roll < 90) begin
         build_frame($urandom_range(0, 2), 8'h00, 1'b0, -1, 10);
      end else begin
         repeat ($urandom_range(1, 6)) begin
            do b = 8'($urandom_range(0, 255));
            while (b == START_BYTE);
            add_link_byte(b);
         end
      end
   endtask

   // one link byte through the request queue
   task automatic send_link_byte(input logic [7:0] b);
      while (!calm_window() && $urandom_range(0, 99) < 29) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push      <= 1'b1;
      req_link_byte <= b;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sb.note_link_byte(b);
      n_in++;
   endtask

   // stimulus and end of run
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // directed: noise while hunting, short length, raw start byte as payload,
      // bad escapes everywhere with crc mismatch ahead of an unknown command
      add_link_byte(ESC_BYTE);
      add_link_byte(8'hFF);
      add_link_byte(8'h00);
      add_link_byte(START_BYTE);
      add_link_byte(8'h02);
      add_link_byte(8'h00);
      build_frame(4, CMD_MAX, 1'b0, int'(START_BYTE), 0);
      build_frame(3, 8'h09, 1'b1, -1, 100);
      while (link_stream.size() < STIM_BYTES) build_random();
      foreach (link_stream[i]) send_link_byte(link_stream[i]);
      req_push <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("PASS escaped_crc16_frame_receiver");
      end else begin
         $display("FAIL escaped_crc16_frame_receiver");
      end
      $finish;
   end

   // response side: check each transfer, random pop with one long hold-off
   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_pop && !rsp_empty) begin
         got.kind   = rsp_item_kind;
         got.data   = rsp_payload_byte;
         got.cmd    = rsp_command_id;
         got.status = rsp_frame_status;
         sb.check_item(got);
      end
      if (!hold_done && n_in >= 300) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= calm_window() || ($urandom_range(0, 99) >= 29);
      end
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL escaped_crc16_frame_receiver");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule
